>>> rtl/pfcd_pkg.sv
// shared types and constants for the pixel format converter with ordered dither
package pfcd_pkg;

  // field widths
  localparam int unsigned PixelW    = 32;
  localparam int unsigned PosW      = 12;
  localparam int unsigned ValueW    = 24;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned CountW    = 2;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned ChanOutW  = 6;
  localparam int unsigned PitchW    = 16;
  localparam int unsigned TableW    = 64;

  // configuration port
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] RegPixelFormat    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDitherEnable   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLinePitch      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFrameBase      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDitherTableLow = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDitherTableHi  = 3'd5;

  // pixel format codes; any code with the upper bit set is 8:8:8
  localparam logic [1:0] FmtRgb555 = 2'd0;
  localparam logic [1:0] FmtRgb565 = 2'd1;
  localparam logic [1:0] FmtRgb888 = 2'd2;

  // bytes stored per pixel
  localparam logic [CountW-1:0] BytesNarrow = 2'd2;
  localparam logic [CountW-1:0] BytesWide   = 2'd3;

  // ordered dither matrix, side length must be a power of two
  localparam int unsigned DitherSize    = 4;
  localparam int unsigned DitherPosW    = $clog2(DitherSize);
  localparam int unsigned TableEntries  = 16;
  localparam int unsigned TableIdxW     = $clog2(TableEntries);

  // channel maxima after scaling
  localparam logic [ChanOutW-1:0] Max5 = 6'd31;
  localparam logic [ChanOutW-1:0] Max6 = 6'd63;

  typedef struct packed {
    logic [PixelW-1:0] source_pixel;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
  } in_t;

  typedef struct packed {
    logic [ValueW-1:0] pixel_value;
    logic [AddrW-1:0]  byte_address;
    logic [CountW-1:0] byte_count;
  } out_t;

  // per-channel control from the top level
  typedef struct packed {
    logic dither_en;
    logic six_bit;
  } chan_ctrl_t;

endpackage

>>> rtl/pfcd_chan.sv
// one colour channel: optional dither add, scale to 5 or 6 bits, saturate
module pfcd_chan (
  input  logic [pfcd_pkg::ChanW-1:0]    chan_i,
  input  logic [pfcd_pkg::ChanW-1:0]    dither_i,
  input  pfcd_pkg::chan_ctrl_t          ctrl_i,
  output logic [pfcd_pkg::ChanOutW-1:0] chan_o
);
  import pfcd_pkg::*;

  logic [8:0]          dith_add;
  logic [8:0]          sum;
  logic [14:0]         prod;
  logic [15:0]         div_tmp;
  logic [6:0]          quot;
  logic [ChanOutW-1:0] maxv;
  logic [ChanOutW-1:0] sat;
  logic [ChanOutW-1:0] trunc;

  // dither offset is entry/16 for six-bit green, entry/8 otherwise
  assign dith_add = ctrl_i.six_bit ? 9'(dither_i >> 4) : 9'(dither_i >> 3);
  assign sum      = 9'(chan_i) + dith_add;
  assign maxv     = ctrl_i.six_bit ? Max6 : Max5;
  assign prod     = 15'(sum) * 15'(maxv);

  // divide by 255: (p + 1 + p/256) / 256 is exact for p below 65535
  assign div_tmp = 16'(prod) + 16'd1 + 16'(prod >> 8);
  assign quot    = 7'(div_tmp[15:8]);

  // saturate at the channel maximum
  assign sat = (quot > 7'(maxv)) ? maxv : quot[ChanOutW-1:0];

  // plain truncation when dither is off
  assign trunc = ctrl_i.six_bit ? ChanOutW'(chan_i >> 2) : ChanOutW'(chan_i >> 3);

  assign chan_o = ctrl_i.dither_en ? sat : trunc;

endmodule

>>> rtl/pixel_format_convert_dither.sv
// top level: pixel format converter with ordered dither and frame buffer addressing
//
// Converts one 8:8:8 source pixel per clock to 5:5:5, 5:6:5 or 8:8:8 and computes
// its frame buffer byte address, base + x*bytes + y*pitch, wrapping at 48 bits. A
// transaction is taken into an input register and its result is moved into the
// output register when that register is free or being emptied; throughput is one
// pixel per clock as long as out_stall_i is low. The input side keeps accepting
// while a finished result waits in the output register; it stalls only when both
// registers are full and the output is held. In the 15 and 16 bit modes
// dither_enable adds an entry of the 4x4 dither table, selected by the low bits
// of y and x, before each channel is scaled with saturation. Configuration writes
// are always ready and should be made only while no pixel is in flight.
module pixel_format_convert_dither (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfcd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pfcd_pkg::CfgDataW-1:0]  cfg_data_i,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pfcd_pkg::in_t                  in_data_i,
  // pixel output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pfcd_pkg::out_t                 out_data_o
);
  import pfcd_pkg::*;

  // configuration registers
  logic [1:0]        pixel_format_q;
  logic              dither_enable_q;
  logic [PitchW-1:0] line_pitch_q;
  logic [AddrW-1:0]  frame_base_q;
  logic [TableW-1:0] dither_table_low_q;
  logic [TableW-1:0] dither_table_high_q;

  // pipeline registers
  logic  s1_valid_q, s1_valid_d;
  in_t   s1_q;
  logic  out_valid_q, out_valid_d;
  out_t  out_q, out_d;

  logic  in_accept;
  logic  s1_adv;
  logic  cfg_write;

  // conversion datapath
  logic                     wide;
  logic                     six_bit;
  logic [2*TableW-1:0]      table_all;
  logic [2*DitherPosW-1:0]  pos_idx;
  logic [TableIdxW-1:0]     tab_idx;
  logic [ChanW-1:0]         dith;
  chan_ctrl_t               ctrl_rb;
  chan_ctrl_t               ctrl_g;
  logic [ChanOutW-1:0]      red_c;
  logic [ChanOutW-1:0]      green_c;
  logic [ChanOutW-1:0]      blue_c;
  logic [ValueW-1:0]        packed_val;
  logic [PosW+1:0]          x_term;
  logic [PosW+PitchW-1:0]   y_term;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  // configuration register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q      <= FmtRgb565;
      dither_enable_q     <= 1'b0;
      line_pitch_q        <= '0;
      frame_base_q        <= '0;
      dither_table_low_q  <= '0;
      dither_table_high_q <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        RegPixelFormat:    pixel_format_q      <= cfg_data_i[1:0];
        RegDitherEnable:   dither_enable_q     <= cfg_data_i[0];
        RegLinePitch:      line_pitch_q        <= cfg_data_i[PitchW-1:0];
        RegFrameBase:      frame_base_q        <= cfg_data_i[AddrW-1:0];
        RegDitherTableLow: dither_table_low_q  <= cfg_data_i;
        RegDitherTableHi:  dither_table_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign s1_adv      = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = s1_valid_q & out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_accept | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
  end

  // dither table lookup from the low position bits
  assign wide      = pixel_format_q[1];
  assign six_bit   = (pixel_format_q == FmtRgb565);
  assign table_all = {dither_table_high_q, dither_table_low_q};
  assign pos_idx   = {s1_q.pos_y[DitherPosW-1:0], s1_q.pos_x[DitherPosW-1:0]};
  assign tab_idx   = TableIdxW'(pos_idx);
  assign dith      = table_all[tab_idx*ChanW +: ChanW];

  assign ctrl_rb = '{dither_en: dither_enable_q, six_bit: 1'b0};
  assign ctrl_g  = '{dither_en: dither_enable_q, six_bit: six_bit};

  pfcd_chan u_red (
    .chan_i   (s1_q.source_pixel[23:16]),
    .dither_i (dith),
    .ctrl_i   (ctrl_rb),
    .chan_o   (red_c)
  );

  pfcd_chan u_green (
    .chan_i   (s1_q.source_pixel[15:8]),
    .dither_i (dith),
    .ctrl_i   (ctrl_g),
    .chan_o   (green_c)
  );

  pfcd_chan u_blue (
    .chan_i   (s1_q.source_pixel[7:0]),
    .dither_i (dith),
    .ctrl_i   (ctrl_rb),
    .chan_o   (blue_c)
  );

  // pack channels in the configured layout
  always_comb begin
    if (wide) begin
      packed_val = s1_q.source_pixel[ValueW-1:0];
    end else if (six_bit) begin
      packed_val = {8'd0, red_c[4:0], green_c, blue_c[4:0]};
    end else begin
      packed_val = {8'd0, 1'b0, red_c[4:0], green_c[4:0], blue_c[4:0]};
    end
  end

  // byte address: base + x*bytes + y*pitch, modulo 2^48
  assign x_term = wide ? ((PosW+2)'(s1_q.pos_x) << 1) + (PosW+2)'(s1_q.pos_x)
                       : ((PosW+2)'(s1_q.pos_x) << 1);
  assign y_term = (PosW+PitchW)'(s1_q.pos_y) * (PosW+PitchW)'(line_pitch_q);

  always_comb begin
    out_d.pixel_value  = packed_val;
    out_d.byte_address = frame_base_q + AddrW'(x_term) + AddrW'(y_term);
    out_d.byte_count   = wide ? BytesWide : BytesNarrow;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a held result with a full input register keeps that transaction in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> s1_valid_q)
    else $error("input register lost a transaction while the output was held");

  // the input side stalls only when the input register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // a taken result with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after it was taken");

  // two-byte pixels never carry bits in the top byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_count == BytesNarrow)
      |-> (out_data_o.pixel_value[23:16] == 8'd0))
    else $error("narrow pixel has bits set above bit 15");

  // the byte count is always two or three
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_count == BytesNarrow ||
                     out_data_o.byte_count == BytesWide))
    else $error("byte count out of range");

endmodule

>>> test/tb_top.sv
// testbench for the pixel format converter with ordered dither
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfcd_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0]         FmtSpare   = 2'd3;   // unused code, behaves as 8:8:8
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;   // no register behind these
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam logic [AddrW-1:0]  AddrMax  = '1;
  localparam logic [TableW-1:0] TabFull  = '1;
  localparam logic [TableW-1:0] TabRampLo = 64'h7868_5848_3828_1808;
  localparam logic [TableW-1:0] TabRampHi = 64'hF8E8_D8C8_B8A8_9888;

  localparam int DrainCycles   = 4;
  localparam int BlocksPerPhase = 6;
  localparam int PixelsPerBlock = 39;

  // one directed row: settings, the pixel, and a hand-worked result where obvious
  typedef struct packed {
    logic [1:0]        fmt;
    logic              dith;
    logic [PitchW-1:0] pitch;
    logic [AddrW-1:0]  base;
    logic [TableW-1:0] tab_lo;
    logic [TableW-1:0] tab_hi;
    in_t               pix;
    logic              typed;
    out_t              want;
  } dir_row_t;

  localparam int NumDirRows = 18;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // reset settings: black, then white at the far corner
    '{FmtRgb565, 1'b0, 16'h0, 48'h0, 64'h0, 64'h0, '{32'h0, 12'h0, 12'h0},
      1'b1, '{24'h0, 48'h0, BytesNarrow}},
    '{FmtRgb565, 1'b0, 16'h0, 48'h0, 64'h0, 64'h0, '{32'hFFFF_FFFF, 12'hFFF, 12'hFFF},
      1'b1, '{24'hFFFF, 48'h1FFE, BytesNarrow}},
    // 5:5:5 truncation, top bit clear, unused byte ignored
    '{FmtRgb555, 1'b0, 16'h0, 48'h0, 64'h0, 64'h0, '{32'h00FF_FFFF, 12'h0, 12'h0},
      1'b1, '{24'h7FFF, 48'h0, BytesNarrow}},
    '{FmtRgb555, 1'b0, 16'h0, 48'h0, 64'h0, 64'h0, '{32'hFF00_0000, 12'h1, 12'h0},
      1'b1, '{24'h0, 48'h2, BytesNarrow}},
    '{FmtRgb555, 1'b0, 16'h0, 48'h0, 64'h0, 64'h0, '{32'h0012_3456, 12'h5, 12'h9},
      1'b0, '0},
    // 8:8:8 pass-through, and the unused format code with dither on
    '{FmtRgb888, 1'b0, 16'h0, 48'h0, 64'h0, 64'h0, '{32'hAB12_3456, 12'h1, 12'h0},
      1'b1, '{24'h12_3456, 48'h3, BytesWide}},
    '{FmtSpare, 1'b1, 16'h0, 48'h0, TabFull, TabFull, '{32'h00AB_CDEF, 12'h0, 12'h0},
      1'b1, '{24'hAB_CDEF, 48'h0, BytesWide}},
    // address wrap at 48 bits
    '{FmtRgb888, 1'b0, 16'hFFFF, AddrMax, 64'h0, 64'h0, '{32'h0, 12'hFFF, 12'hFFF},
      1'b0, '0},
    // dithered channels saturating at their maxima
    '{FmtRgb565, 1'b1, 16'hFFFF, AddrMax, TabFull, TabFull, '{32'h00FF_FFFF, 12'h0, 12'h0},
      1'b1, '{24'hFFFF, AddrMax, BytesNarrow}},
    '{FmtRgb555, 1'b1, 16'hFFFF, AddrMax, TabFull, TabFull, '{32'h00FF_FFFF, 12'h0, 12'h0},
      1'b1, '{24'h7FFF, AddrMax, BytesNarrow}},
    '{FmtRgb565, 1'b1, 16'h0, 48'h0, TabFull, TabFull, '{32'h0, 12'h0, 12'h0},
      1'b0, '0},
    // ramp table, entries reached through several x,y phases
    '{FmtRgb565, 1'b1, 16'h0140, 48'h1000_0000, TabRampLo, TabRampHi,
      '{32'h0080_8080, 12'h1, 12'h0}, 1'b0, '0},
    '{FmtRgb565, 1'b1, 16'h0140, 48'h1000_0000, TabRampLo, TabRampHi,
      '{32'h00F0_F0F0, 12'h2, 12'h1}, 1'b0, '0},
    '{FmtRgb565, 1'b1, 16'h0140, 48'h1000_0000, TabRampLo, TabRampHi,
      '{32'h0007_0307, 12'h3, 12'h2}, 1'b0, '0},
    '{FmtRgb565, 1'b1, 16'h0140, 48'h1000_0000, TabRampLo, TabRampHi,
      '{32'h00FC_FDFE, 12'h5, 12'h3}, 1'b0, '0},
    '{FmtRgb555, 1'b1, 16'h0140, 48'h1000_0000, TabRampLo, TabRampHi,
      '{32'h00FF_FCF8, 12'hFFE, 12'hFFD}, 1'b0, '0},
    '{FmtRgb555, 1'b1, 16'h0140, 48'h1000_0000, TabRampLo, TabRampHi,
      '{32'h00FF_00FF, 12'h7, 12'h6}, 1'b0, '0},
    // dither off with a table loaded: low bits simply dropped
    '{FmtRgb565, 1'b0, 16'h1, 48'h0, TabRampLo, TabRampHi,
      '{32'h0007_0307, 12'hFFF, 12'hFFF}, 1'b0, '0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;

  // shadow of the configuration registers, reset values
  logic [1:0]        cfg_fmt    = FmtRgb565;
  logic              cfg_dith   = 1'b0;
  logic [PitchW-1:0] cfg_pitch  = '0;
  logic [AddrW-1:0]  cfg_base   = '0;
  logic [TableW-1:0] cfg_tab_lo = '0;
  logic [TableW-1:0] cfg_tab_hi = '0;

  out_t pending_px_q[$];
  int   err_count   = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;

  pixel_format_convert_dither uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // scale one channel with dither added, clamped at its maximum
  function automatic int unsigned scale_chan(int unsigned c, int unsigned add,
                                             int unsigned maxv);
    int unsigned v;
    v = (c + add) * maxv / 255;
    return (v > maxv) ? maxv : v;
  endfunction

  // expected converted pixel and address under the current settings
  function automatic out_t convert_pixel(in_t p);
    out_t        res;
    int unsigned r, g, b, rr, gg, bb, idx, d;
    logic        six;
    logic [TableW-1:0] word;
    r = p.source_pixel[23:16];
    g = p.source_pixel[15:8];
    b = p.source_pixel[7:0];
    six = (cfg_fmt == FmtRgb565);
    if (cfg_fmt[1]) begin
      res.pixel_value = p.source_pixel[ValueW-1:0];
      res.byte_count  = BytesWide;
    end else begin
      if (cfg_dith) begin
        idx  = (p.pos_y % DitherSize) * DitherSize + (p.pos_x % DitherSize);
        word = (idx < 8) ? cfg_tab_lo : cfg_tab_hi;
        d    = word[(idx % 8) * 8 +: 8];
        rr = scale_chan(r, d / 8, Max5);
        bb = scale_chan(b, d / 8, Max5);
        gg = six ? scale_chan(g, d / 16, Max6) : scale_chan(g, d / 8, Max5);
      end else begin
        rr = r >> 3;
        bb = b >> 3;
        gg = six ? (g >> 2) : (g >> 3);
      end
      res.pixel_value = six ? ValueW'((rr << 11) | (gg << 5) | bb)
                            : ValueW'((rr << 10) | (gg << 5) | bb);
      res.byte_count  = BytesNarrow;
    end
    res.byte_address = cfg_base + AddrW'(p.pos_x) * AddrW'(res.byte_count)
                     + AddrW'(p.pos_y) * AddrW'(cfg_pitch);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
    err_count++;
  endtask

  // hold off until every pixel in flight has come out
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (pending_px_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one register write transaction; valid is left high for the caller to drop
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegPixelFormat:    cfg_fmt    = data[1:0];
      RegDitherEnable:   cfg_dith   = data[0];
      RegLinePitch:      cfg_pitch  = data[PitchW-1:0];
      RegFrameBase:      cfg_base   = data[AddrW-1:0];
      RegDitherTableLow: cfg_tab_lo = data;
      RegDitherTableHi:  cfg_tab_hi = data;
      default: ;
    endcase
  endtask

  // full register set, written only once the block is idle
  task automatic load_settings(input logic [1:0] fmt, input logic dith,
                               input logic [PitchW-1:0] pitch, input logic [AddrW-1:0] base,
                               input logic [TableW-1:0] tab_lo,
                               input logic [TableW-1:0] tab_hi, input logic spare);
    drain_pixels();
    // upper data bits set on purpose: the block must mask them
    write_reg(RegPixelFormat, {{(CfgDataW-2){1'b1}}, fmt});
    write_reg(RegDitherEnable, {{(CfgDataW-1){dith}}, dith});
    write_reg(RegLinePitch, {{(CfgDataW-PitchW){1'b1}}, pitch});
    write_reg(RegFrameBase, {{(CfgDataW-AddrW){1'b1}}, base});
    write_reg(RegDitherTableLow, tab_lo);
    write_reg(RegDitherTableHi, tab_hi);
    if (spare) begin
      write_reg(RegSpareLo, {$urandom, $urandom});
      write_reg(RegSpareHi, {$urandom, $urandom});
    end
    cfg_valid_i <= 1'b0;
  endtask

  // one pixel transaction, with random idle cycles ahead of it
  task automatic send_pixel(input in_t pix, input logic typed, input out_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pix;
    do @(posedge clk_i); while (in_stall_o);
    pending_px_q.push_back(typed ? want : convert_pixel(pix));
  endtask

  function automatic logic [AddrW-1:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return AddrMax;
      default: return AddrW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [TableW-1:0] pick_table();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return TabFull;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PosW'($urandom_range(0, 4095));
    endcase
  endfunction

  // output side: random stall, check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px_q.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.byte_address, 0);
      end else begin
        out_t want;
        want = pending_px_q.pop_front();
        if (out_data_o.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", out_data_o.pixel_value, want.pixel_value);
        if (out_data_o.byte_address !== want.byte_address)
          report_mismatch("byte_address", out_data_o.byte_address, want.byte_address);
        if (out_data_o.byte_count !== want.byte_count)
          report_mismatch("byte_count", out_data_o.byte_count, want.byte_count);
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // stimulus
  initial begin
    dir_row_t row;
    in_t      pix;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 33;
    rx_idle_pct = 60;

    // writes to unmapped indexes must leave the reset settings alone
    write_reg(RegSpareLo, '1);
    write_reg(RegSpareHi, '1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);

    // directed rows
    for (int i = 0; i < NumDirRows; i++) begin
      row = DirRows[i];
      if (row.fmt != cfg_fmt || row.dith != cfg_dith || row.pitch != cfg_pitch ||
          row.base != cfg_base || row.tab_lo != cfg_tab_lo || row.tab_hi != cfg_tab_hi)
        load_settings(row.fmt, row.dith, row.pitch, row.base, row.tab_lo, row.tab_hi, 1'b0);
      send_pixel(row.pix, row.typed, row.want);
    end

    // random pixels in three idling phases, settings changed per block
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 33; rx_idle_pct = 60; end
        1: begin tx_idle_pct = 60; rx_idle_pct = 33; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < BlocksPerPhase; blk++) begin
        load_settings(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0) ? 16'hFFFF : PitchW'($urandom),
                      pick_base(), pick_table(), pick_table(),
                      ($urandom_range(0, 3) == 0));
        for (int n = 0; n < PixelsPerBlock; n++) begin
          pix.source_pixel = $urandom;
          pix.pos_x        = pick_pos();
          pix.pos_y        = pick_pos();
          send_pixel(pix, 1'b0, '0);
        end
      end
    end

    // wind down
    drain_pixels();
    if (pending_px_q.size() != 0)
      report_mismatch("missing results", pending_px_q.size(), 0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pfcd_pkg.sv
rtl/pfcd_chan.sv
rtl/pixel_format_convert_dither.sv
test/tb_top.sv
